>>> hw/rtl/gdad_pkg.sv
// Shared types, constants and helpers for the Gregorian date offset unit.
// Depends on nothing; imported by every module of the unit.
package gdad_pkg;

   // Divide by constant: x * floor(2^24 / c) >> 24, then one correction step.
   localparam int unsigned RCP_SHIFT = 24;
   localparam logic [23:0] RCP_100   = 24'((2 ** RCP_SHIFT) / 100);
   localparam logic [23:0] RCP_365   = 24'((2 ** RCP_SHIFT) / 365);
   localparam logic [23:0] RCP_1460  = 24'((2 ** RCP_SHIFT) / 1460);
   localparam logic [23:0] RCP_36524 = 24'((2 ** RCP_SHIFT) / 36524);
   localparam logic [23:0] RCP_ERA   = 24'((2 ** RCP_SHIFT) / 146097);

   localparam logic [23:0] DAYS_PER_ERA = 24'd146097;
   localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
   localparam logic [13:0] YEAR_MAX     = 14'd9999;
   localparam logic [13:0] YEAR_BIAS    = 14'd400;

   typedef struct packed {
      logic [23:0] quo;
      logic [23:0] rem;
   } divmod_type;

   // Request payload as unpacked from tdata.
   typedef struct packed {
      logic [13:0]        year;
      logic [6:0]         month;
      logic [6:0]         day;
      logic signed [15:0] delta;
   } date_req_type;

   // Hand-off between forward and reverse converters.
   typedef struct packed {
      logic        ok;
      logic [21:0] serial;
   } serial_type;

   // Response payload.
   typedef struct packed {
      logic        date_valid;
      logic        year_out_of_range;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_rsp_type;

   // Exact for x < 2^24: the reciprocal estimate is low by at most one.
   function automatic divmod_type div_const(input logic [23:0] x,
                                            input logic [23:0] c,
                                            input logic [23:0] rcp);
      logic [47:0] prod;
      logic [23:0] q0;
      logic [23:0] r0;
      divmod_type  res;
      prod = {24'b0, x} * {24'b0, rcp};
      q0   = prod[47:24];
      r0   = x - (q0 * c);
      if (r0 >= c) begin
         res.quo = q0 + 24'd1;
         res.rem = r0 - c;
      end else begin
         res.quo = q0;
         res.rem = r0;
      end
      return res;
   endfunction

   // First day of month index mp in a March-based year (0 = March, 11 = February).
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

>>> hw/rtl/gdad_to_serial.sv
// Forward converter: date check, then civil date plus offset to a serial day count.
// Three pipeline stages; depends on gdad_pkg.
module gdad_to_serial (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  gdad_pkg::date_req_type    in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output gdad_pkg::serial_type      out_data
);
   import gdad_pkg::*;

   localparam logic [6:0] MONTH_JAN = 7'd1;
   localparam logic [6:0] MONTH_FEB = 7'd2;
   localparam logic [6:0] MONTH_DEC = 7'd12;

   typedef struct packed {
      logic               ok;
      logic [13:0]        year_sh;   // March-based year + 400
      logic [8:0]         doy;
      logic signed [15:0] delta;
   } st1_type;

   typedef struct packed {
      logic               ok;
      logic [21:0]        days_yr;   // 365*Y + Y/4
      logic [6:0]         cent;      // Y/100
      logic signed [16:0] doy_delta;
   } st2_type;

   logic [2:0] valid_ff, valid_in, en;
   st1_type    s1_ff, s1_in;
   st2_type    s2_ff, s2_in;
   serial_type s3_ff, s3_in;

   // stage ready chain: a stage loads when empty or when its successor moves
   assign en[2]    = !valid_ff[2] || out_ready;
   assign en[1]    = !valid_ff[1] || en[2];
   assign en[0]    = !valid_ff[0] || en[1];
   assign in_ready = en[0];

   assign valid_in[0] = en[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];

   // stage 1: validity and March-based year / day of year
   always_comb begin
      divmod_type dm;
      logic       is_leap;
      logic [4:0] mlen;
      logic       jan_feb;
      logic [3:0] mp;
      logic [9:0] doy_w;
      dm      = div_const({10'b0, in_data.year}, 24'd100, RCP_100);
      is_leap = (in_data.year[1:0] == 2'b00) &&
                ((dm.rem[6:0] != 7'd0) || (dm.quo[1:0] == 2'b00));
      mlen = 5'd31;
      if (in_data.month inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
         mlen = 5'd30;
      end else if (in_data.month == MONTH_FEB) begin
         mlen = is_leap ? 5'd29 : 5'd28;
      end
      s1_in.ok = (in_data.year <= YEAR_MAX) &&
                 (in_data.month >= MONTH_JAN) && (in_data.month <= MONTH_DEC) &&
                 (in_data.day != 7'd0) && (in_data.day <= {2'b0, mlen});
      jan_feb         = (in_data.month <= MONTH_FEB);
      s1_in.year_sh   = in_data.year + YEAR_BIAS - {13'b0, jan_feb};
      mp              = jan_feb ? 4'(in_data.month + 7'd9) : 4'(in_data.month - 7'd3);
      doy_w           = {1'b0, month_start(mp)} + {3'b0, in_data.day} - 10'd1;
      s1_in.doy       = doy_w[8:0];
      s1_in.delta     = in_data.delta;
   end

   // stage 2: year part of the day count
   always_comb begin
      divmod_type dm;
      dm              = div_const({10'b0, s1_ff.year_sh}, 24'd100, RCP_100);
      s2_in.ok        = s1_ff.ok;
      s2_in.days_yr   = (22'(s1_ff.year_sh) * 22'd365) + 22'(s1_ff.year_sh[13:2]);
      s2_in.cent      = dm.quo[6:0];
      s2_in.doy_delta = $signed({8'b0, s1_ff.doy}) + 17'(s1_ff.delta);
   end

   // stage 3: serial day, always positive thanks to the one-era bias
   always_comb begin
      logic signed [23:0] n;
      n = $signed({2'b0, s2_ff.days_yr}) - $signed({17'b0, s2_ff.cent})
          + $signed({19'b0, s2_ff.cent[6:2]}) + 24'(s2_ff.doy_delta);
      s3_in.ok     = s2_ff.ok;
      s3_in.serial = n[21:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
      if (en[1]) begin
         s2_ff <= s2_in;
      end
      if (en[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = s3_ff;

endmodule

>>> hw/rtl/gdad_from_serial.sv
// Reverse converter: serial day count back to a civil date, with range check.
// Five pipeline stages, the last one is the response register; depends on gdad_pkg.
module gdad_from_serial (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  gdad_pkg::serial_type      in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output gdad_pkg::date_rsp_type    out_data
);
   import gdad_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [4:0]  era;
      logic [17:0] doe;
   } st4_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  era;
      logic [17:0] doe;
      logic [17:0] adj;   // doe with leap days taken out
   } st5_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  era;
      logic [17:0] doe;
      logic [8:0]  yoe;
   } st6_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  era;
      logic [8:0]  yoe;
      logic [8:0]  doy;
   } st7_type;

   logic [4:0]   valid_ff, valid_in, en;
   st4_type      s4_ff, s4_in;
   st5_type      s5_ff, s5_in;
   st6_type      s6_ff, s6_in;
   st7_type      s7_ff, s7_in;
   date_rsp_type s8_ff, s8_in;

   assign en[4]    = !valid_ff[4] || out_ready;
   assign en[3]    = !valid_ff[3] || en[4];
   assign en[2]    = !valid_ff[2] || en[3];
   assign en[1]    = !valid_ff[1] || en[2];
   assign en[0]    = !valid_ff[0] || en[1];
   assign in_ready = en[0];

   assign valid_in[0] = en[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   assign valid_in[3] = en[3] ? valid_ff[2] : valid_ff[3];
   assign valid_in[4] = en[4] ? valid_ff[3] : valid_ff[4];

   // era and day of era
   always_comb begin
      divmod_type dm;
      dm        = div_const({2'b0, in_data.serial}, DAYS_PER_ERA, RCP_ERA);
      s4_in.ok  = in_data.ok;
      s4_in.era = dm.quo[4:0];
      s4_in.doe = dm.rem[17:0];
   end

   // remove the 4/100/400-year leap corrections
   always_comb begin
      divmod_type d4, d100;
      d4        = div_const({6'b0, s4_ff.doe}, 24'd1460, RCP_1460);
      d100      = div_const({6'b0, s4_ff.doe}, 24'd36524, RCP_36524);
      s5_in.ok  = s4_ff.ok;
      s5_in.era = s4_ff.era;
      s5_in.doe = s4_ff.doe;
      s5_in.adj = s4_ff.doe - {11'b0, d4.quo[6:0]} + {15'b0, d100.quo[2:0]}
                  - {17'b0, (s4_ff.doe == ERA_LAST_DAY)};
   end

   // year of era
   always_comb begin
      divmod_type dm;
      dm        = div_const({6'b0, s5_ff.adj}, 24'd365, RCP_365);
      s6_in.ok  = s5_ff.ok;
      s6_in.era = s5_ff.era;
      s6_in.doe = s5_ff.doe;
      s6_in.yoe = dm.quo[8:0];
   end

   // day of the March-based year
   always_comb begin
      divmod_type  dm;
      logic [18:0] doy_w;
      dm    = div_const({15'b0, s6_ff.yoe}, 24'd100, RCP_100);
      doy_w = {1'b0, s6_ff.doe} - (19'(s6_ff.yoe) * 19'd365)
              - {12'b0, s6_ff.yoe[8:2]} + {17'b0, dm.quo[1:0]};
      s7_in.ok  = s6_ff.ok;
      s7_in.era = s6_ff.era;
      s7_in.yoe = s6_ff.yoe;
      s7_in.doy = doy_w[8:0];
   end

   // month by table search, civil year, range check, zeroing
   always_comb begin
      logic [3:0]         mp;
      logic [8:0]         dom;
      logic [3:0]         month;
      logic               jan_feb;
      logic signed [16:0] year_s;
      logic               oor;
      mp = 4'd0;
      for (int i = 1; i < 12; i++) begin
         mp = mp + 4'(s7_ff.doy >= month_start(4'(i)));
      end
      dom     = s7_ff.doy - month_start(mp) + 9'd1;
      jan_feb = (mp >= 4'd10);
      month   = jan_feb ? (mp - 4'd9) : (mp + 4'd3);
      year_s  = $signed(17'(s7_ff.era) * 17'd400) + $signed({8'b0, s7_ff.yoe})
                + $signed({16'b0, jan_feb}) - $signed({3'b0, YEAR_BIAS});
      oor     = (year_s < 17'sd0) || (year_s > $signed({3'b0, YEAR_MAX}));
      s8_in.date_valid        = s7_ff.ok;
      s8_in.year_out_of_range = s7_ff.ok && oor;
      if (s7_ff.ok && !oor) begin
         s8_in.year  = year_s[13:0];
         s8_in.month = month;
         s8_in.day   = dom[4:0];
      end else begin
         s8_in.year  = '0;
         s8_in.month = '0;
         s8_in.day   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s4_ff <= s4_in;
      end
      if (en[1]) begin
         s5_ff <= s5_in;
      end
      if (en[2]) begin
         s6_ff <= s6_in;
      end
      if (en[3]) begin
         s7_ff <= s7_in;
      end
      if (en[4]) begin
         s8_ff <= s8_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = s8_ff;

endmodule

>>> hw/rtl/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date offset unit: stream ports and packing.
// Depends on gdad_pkg, gdad_to_serial and gdad_from_serial.
//
// Usage:
//   req channel carries one transaction per date: start year, month, day and a
//   signed day offset. rsp channel returns exactly one transaction per request,
//   in order: the shifted date plus two flags in tuser.
//   An invalid start date (bad month, bad day, year above 9999) answers with
//   all fields zero; a result year outside 0..9999 sets both flags and zeros
//   the date.
// Pipeline: 8 register stages (3 forward, 5 reverse, the last being the
//   response register); with rsp_tready high the response is taken as soon
//   as rsp_tvalid rises.
// Throughput: one transaction per cycle while rsp_tready stays high; most stages
//   hold one or two constant-divide steps (reciprocal multiply plus one correction), which sets the stage depth.
// Reset: clears every stage valid bit; the pipeline comes up empty and ready.
// Stall: when rsp_tready is low the response register holds; earlier stages
//   keep loading until they run into a full stage, so req_tready drops only
//   once all eight stages hold a transaction. Nothing is lost or repeated.
module gregorian_date_add_days_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // in_year[13:0], in_month[20:14], in_day[27:21],
                                    // day_offset[43:28], zero pad[47:44]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_year[13:0], out_month[17:14], out_day[22:18],
                                    // zero pad[23]
   output logic [1:0]  rsp_tuser    // date_valid[0], year_out_of_range[1]
);
   import gdad_pkg::*;

   date_req_type req;
   serial_type   mid_data;
   logic         mid_valid;
   logic         mid_ready;
   date_rsp_type rsp;

   assign req.year  = req_tdata[13:0];
   assign req.month = req_tdata[20:14];
   assign req.day   = req_tdata[27:21];
   assign req.delta = $signed(req_tdata[43:28]);

   gdad_to_serial u_to_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   gdad_from_serial u_from_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.day, rsp.month, rsp.year};
   assign rsp_tuser = {rsp.year_out_of_range, rsp.date_valid};

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // range flag only on a valid start date
   a_oor_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("range flag without valid date");

   // flagged responses carry a zero date
   a_zero_when_flagged: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (!rsp_tuser[0] || rsp_tuser[1]) |-> (rsp_tdata == 24'd0))
      else $error("nonzero date on flagged response");

   // a good response holds a real calendar date
   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1] |->
         (rsp_tdata[17:14] >= 4'd1) && (rsp_tdata[17:14] <= 4'd12) &&
         (rsp_tdata[22:18] != 5'd0) && (rsp_tdata[13:0] <= YEAR_MAX))
      else $error("response date out of calendar bounds");

endmodule

>>> tb/gregorian_date_add_days_unit_tb.sv
// Self-checking bench for gregorian_date_add_days_unit: date plus day offset.
// Depends on the unit RTL and gdad_pkg; needs no files, arguments or seeds.
// Predicts each response in the scoreboard class and checks in-order delivery.
module gregorian_date_add_days_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gdad_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;  // far above the slowest legal run
   localparam int unsigned DRAIN_CYCLES = 24;      // 8-stage pipe plus margin
   localparam int          PHASE_ITEMS [3] = '{170, 170, 160};

   // One predicted response, laid out as the unit reports it.
   typedef struct packed {
      bit        date_valid;
      bit        year_out_of_range;
      bit [13:0] year;
      bit [3:0]  month;
      bit [4:0]  day;
   } shifted_date_type;

   // Scoreboard: predicts each request's response and checks them in order.
   class calendar_scoreboard;
      shifted_date_type due_q[$];
      int unsigned      mismatches;

      static function bit is_leap(longint y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      // Zero for a month outside 1..12.
      static function longint month_length(longint y, longint m);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      static function shifted_date_type shift_date(longint y, longint m, longint d,
                                                   longint delta);
         shifted_date_type res;
         longint           yy, mar_month, day_num, era, doe, yoe, doy, mp;
         longint           new_year, new_month, new_day;
         res = '0;
         if (y > YEAR_MAX || d < 1 || d > month_length(y, m))
            return res;
         res.date_valid = 1'b1;
         // March-based year, pushed up one 400-year cycle so every count stays
         // positive even for January of year 0 minus the largest offset.
         yy        = y + 400 - ((m <= 2) ? 1 : 0);
         mar_month = (m + 9) % 12;
         day_num   = 365 * yy + yy / 4 - yy / 100 + yy / 400
                     + (153 * mar_month + 2) / 5 + d - 1 + delta;
         // Back to a civil date from the day count.
         era       = day_num / 146097;
         doe       = day_num % 146097;
         yoe       = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy       = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp        = (5 * doy + 2) / 153;
         new_day   = doy - (153 * mp + 2) / 5 + 1;
         new_month = (mp < 10) ? mp + 3 : mp - 9;
         new_year  = era * 400 + yoe + ((new_month <= 2) ? 1 : 0) - 400;
         if (new_year < 0 || new_year > YEAR_MAX) begin
            res.year_out_of_range = 1'b1;
            return res;
         end
         res.year  = 14'(new_year);
         res.month = 4'(new_month);
         res.day   = 5'(new_day);
         return res;
      endfunction

      function void note_request(bit [47:0] data);
         due_q.insert(due_q.size(), shift_date(data[13:0], data[20:14], data[27:21],
                                               $signed(data[43:28])));
      endfunction

      function void check_response(bit [23:0] data, bit [1:0] flags);
         shifted_date_type want;
         if (due_q.size() == 0) begin
            $error("rsp transaction with no request outstanding: tdata=%h tuser=%b",
                   data, flags);
            mismatches++;
            return;
         end
         want = due_q.pop_front();
         if (flags[0] !== want.date_valid) begin
            $error("date_valid: expected %0d, got %0d", want.date_valid, flags[0]);
            mismatches++;
         end
         if (flags[1] !== want.year_out_of_range) begin
            $error("year_out_of_range: expected %0d, got %0d",
                   want.year_out_of_range, flags[1]);
            mismatches++;
         end
         if (data[13:0] !== want.year) begin
            $error("out_year: expected %0d, got %0d", want.year, data[13:0]);
            mismatches++;
         end
         if (data[17:14] !== want.month) begin
            $error("out_month: expected %0d, got %0d", want.month, data[17:14]);
            mismatches++;
         end
         if (data[22:18] !== want.day) begin
            $error("out_day: expected %0d, got %0d", want.day, data[22:18]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // in_year, in_month, in_day, day_offset, pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // out_year, out_month, out_day, pad
   logic [1:0]  rsp_tuser;         // date_valid, year_out_of_range

   int unsigned        send_idle_pct = 29;
   int unsigned        rsp_idle_pct  = 60;
   int unsigned        cycle_count   = 0;
   calendar_scoreboard dates_sb;

   gregorian_date_add_days_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Monitor. Inputs only move at the rising edge, so at the falling edge the
   // handshake signals already show what the next rising edge will accept.
   // The request is noted before the response is checked in the same cycle.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            dates_sb.note_request(req_tdata);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            dates_sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Drive one request transaction, with random idle cycles ahead of it.
   task automatic send_date(input int y, input int m, input int d, input int delta);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, 16'(delta), 7'(d), 7'(m), 14'(y)};
      do begin
         @(negedge clock);
         taken = (req_tready === 1'b1);
         @(posedge clock);
      end while (!taken);
   endtask

   // Mostly well-formed dates, biased toward both ends of the year range so
   // the offset often pushes the result out of 0..9999; the rest is raw noise.
   task automatic send_random_date();
      int roll, y, m, d, delta, mlen;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         send_date($urandom_range(0, 16383), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom_range(0, 65535));
      end else begin
         case ($urandom_range(0, 2))
            0:       y = $urandom_range(0, 120);
            1:       y = $urandom_range(9880, 9999);
            default: y = $urandom_range(0, 9999);
         endcase
         m    = $urandom_range(1, 12);
         mlen = int'(calendar_scoreboard::month_length(y, m));
         // Month ends and leap days are worth extra weight.
         d    = ($urandom_range(0, 3) == 0) ? mlen : $urandom_range(1, mlen);
         case ($urandom_range(0, 3))
            0:       delta = $urandom_range(0, 800) - 400;
            1:       delta = ($urandom_range(0, 1) != 0) ? 32767 - $urandom_range(0, 50)
                                                         : $urandom_range(0, 50) - 32768;
            default: delta = $urandom_range(0, 65535);
         endcase
         send_date(y, m, d, delta);
      end
   endtask

   initial begin
      dates_sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: epoch, range edges, leap rules, invalid fields, offset extremes.
      send_date(1970, 1, 1, 0);
      send_date(0, 1, 1, 0);
      send_date(0, 1, 1, -1);          // result falls before year 0
      send_date(0, 3, 1, -1);          // year 0 is a leap year
      send_date(0, 1, 1, 32767);
      send_date(1, 3, 1, -32768);      // lands before year 0
      send_date(9999, 12, 31, 1);      // result past year 9999
      send_date(9999, 12, 31, -32768);
      send_date(9999, 12, 31, 0);
      send_date(2000, 2, 29, 365);     // leap century
      send_date(1900, 2, 29, 0);       // non-leap century, invalid
      send_date(2023, 2, 29, 1);       // invalid Feb 29
      send_date(2024, 2, 29, 1);
      send_date(2100, 2, 28, 1);
      send_date(2023, 12, 31, 1);
      send_date(1999, 12, 31, 32767);
      send_date(2020, 0, 10, 5);       // month zero
      send_date(2020, 13, 10, 5);      // month past December
      send_date(2020, 5, 0, 5);        // day zero
      send_date(2020, 1, 32, 5);       // day past month end
      send_date(2020, 4, 31, 5);
      send_date(10000, 1, 1, 0);       // year not four digits
      send_date(16383, 127, 127, -1);  // every input bit high
      send_date(0, 0, 0, 0);           // every input bit low

      // Random: idle mixes sender/receiver, then swapped, then none.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               rsp_idle_pct  = 60;
            end
            1: begin
               send_idle_pct = 60;
               rsp_idle_pct  = 29;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS[phase]; n++)
            send_random_date();
      end
      req_tvalid <= 1'b0;

      // Drain outstanding transactions, then watch for stray responses.
      while (dates_sb.due_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (dates_sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
